>>> rtl/mcsl_pkg.sv
// Shared types and constants for the multi-channel slew limiter.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mcsl_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned POS_W     = 12;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STEP_W    = 10;
  localparam int unsigned FGS_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 10;

  // A tick visits at most this many motors; the walk counter can hold it.
  localparam int unsigned WALK_CAP  = 32;
  localparam int unsigned WALK_W    = 6;

  localparam int unsigned NUM_MOTORS_DEF = 32;

  localparam logic [STEP_W-1:0] MAX_STEP_RST = 10'd12;
  localparam logic [FGS_W-1:0]  FGS_RST      = 6'd8;
  localparam logic              HOLD_RST     = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_TARGET  = 2'd0,
    MODE_SET_CURRENT = 2'd1,
    MODE_TICK        = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_STEP = 2'd0,
    CFG_FAST_GRP = 2'd1,
    CFG_HOLD     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic store_tgt;   // write the addressed target from the request
    logic store_cur;   // preload the addressed current position
    logic walk_start;  // reset the walk counter and the pending result
    logic rd_en;       // read both stores at the walk index
    logic commit;      // apply the evaluated motor and advance the walk
    logic flush;       // send the pending result as the last of the tick
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_end;    // no more motors to visit in this tick
    logic moved;       // evaluated motor was away from its target
    logic pend_vld;    // a result is held back until the next one is known
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

>>> rtl/multi_channel_slew_limiter.sv
// Multi-channel slew limiter. A tick visits motors in index order (store
// read, then step and write-back through the single store port), stopping
// after min(NUM_MOTORS, 32) motors, or at the end of the fast group while
// hold is set, and waits while the output is stalled.
// Each tick result is held one motor back so the final one can carry last;
// the output register lets the next request enter while a result still
// waits. Both stores read as zero until an entry is written; there is no
// clearing pass after reset.
// Depends on mcsl_pkg, mcsl_ctrl and mcsl_dp.
`timescale 1ns / 1ps

module multi_channel_slew_limiter #(
  parameter int unsigned NUM_MOTORS = mcsl_pkg::NUM_MOTORS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mcsl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcsl_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mcsl_pkg::MODE_W-1:0]     mode_i,
  input  logic [mcsl_pkg::IDX_W-1:0]      motor_index_i,
  input  logic [mcsl_pkg::POS_W-1:0]      position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mcsl_pkg::IDX_W-1:0]      motor_index_res_o,
  output logic [mcsl_pkg::POS_W-1:0]      goal_position_o,
  output logic                            last_o
);

  mcsl_pkg::cmd_t cmd;
  mcsl_pkg::sts_t sts;

  mcsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcsl_dp #(
    .NUM_MOTORS (NUM_MOTORS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .motor_index_i     (motor_index_i),
    .position_i        (position_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .motor_index_res_o (motor_index_res_o),
    .goal_position_o   (goal_position_o),
    .last_o            (last_o)
  );

`ifndef SYNTH
  // A finished tick must not leave a result behind when requests resume.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.pend_vld)
    else $error("pending result left over while accepting requests");

  // Results only come out of a tick walk.
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared outside a tick walk");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(motor_index_res_o) < NUM_MOTORS))
    else $error("result names a motor that does not exist");
`endif

endmodule

>>> rtl/mcsl_ctrl.sv
// Sequencer for the slew limiter: decodes requests and steps the tick walk.
// Depends on mcsl_pkg; drives the datapath through mcsl_pkg::cmd_t.
`timescale 1ns / 1ps

module mcsl_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mcsl_pkg::MODE_W-1:0]  mode_i,
  input  mcsl_pkg::sts_t               sts_i,
  output mcsl_pkg::cmd_t               cmd_o
);

  mcsl_pkg::state_e state_q, state_d;
  logic             eval_go;

  // Holding back the previous result needs a free output slot.
  assign eval_go = !(sts_i.moved && sts_i.pend_vld) || sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcsl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcsl_pkg::ST_IDLE: begin
        if (in_valid_i && (mode_i == mcsl_pkg::MODE_TICK)) begin
          state_d = mcsl_pkg::ST_READ;
        end
      end
      mcsl_pkg::ST_READ: begin
        state_d = sts_i.walk_end ? mcsl_pkg::ST_FLUSH : mcsl_pkg::ST_EVAL;
      end
      mcsl_pkg::ST_EVAL: begin
        if (eval_go) begin
          state_d = mcsl_pkg::ST_READ;
        end
      end
      mcsl_pkg::ST_FLUSH: begin
        if (!sts_i.pend_vld || sts_i.out_free) begin
          state_d = mcsl_pkg::ST_IDLE;
        end
      end
      default: state_d = mcsl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      mcsl_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.store_tgt  = (mode_i == mcsl_pkg::MODE_SET_TARGET);
          cmd_o.store_cur  = (mode_i == mcsl_pkg::MODE_SET_CURRENT);
          cmd_o.walk_start = (mode_i == mcsl_pkg::MODE_TICK);
        end
      end
      mcsl_pkg::ST_READ: begin
        cmd_o.rd_en = !sts_i.walk_end;
      end
      mcsl_pkg::ST_EVAL: begin
        cmd_o.commit = eval_go;
      end
      mcsl_pkg::ST_FLUSH: begin
        cmd_o.flush = sts_i.pend_vld && sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/mcsl_dp.sv
// Datapath of the slew limiter: position stores, step arithmetic, the held
// result and the output register. Depends on mcsl_pkg; commanded by mcsl_ctrl.
`timescale 1ns / 1ps

module mcsl_dp #(
  parameter int unsigned NUM_MOTORS = mcsl_pkg::NUM_MOTORS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mcsl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcsl_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [mcsl_pkg::IDX_W-1:0]      motor_index_i,
  input  logic [mcsl_pkg::POS_W-1:0]      position_i,
  input  mcsl_pkg::cmd_t                  cmd_i,
  output mcsl_pkg::sts_t                  sts_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mcsl_pkg::IDX_W-1:0]      motor_index_res_o,
  output logic [mcsl_pkg::POS_W-1:0]      goal_position_o,
  output logic                            last_o
);

  localparam int unsigned AW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int unsigned WALK_LEN =
      (NUM_MOTORS < mcsl_pkg::WALK_CAP) ? NUM_MOTORS : mcsl_pkg::WALK_CAP;
  localparam int unsigned PW = mcsl_pkg::POS_W;

  // Configuration registers.
  logic [mcsl_pkg::STEP_W-1:0] max_step_q;
  logic [mcsl_pkg::FGS_W-1:0]  fgs_q;
  logic                        hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= mcsl_pkg::MAX_STEP_RST;
      fgs_q      <= mcsl_pkg::FGS_RST;
      hold_q     <= mcsl_pkg::HOLD_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mcsl_pkg::CFG_MAX_STEP) begin
        max_step_q <= cfg_data_i;
      end
      if (cfg_idx_i == mcsl_pkg::CFG_FAST_GRP) begin
        fgs_q <= cfg_data_i[mcsl_pkg::FGS_W-1:0];
      end
      if (cfg_idx_i == mcsl_pkg::CFG_HOLD) begin
        hold_q <= cfg_data_i[0];
      end
    end
  end

  // Walk counter.
  logic [mcsl_pkg::WALK_W-1:0] walk_idx_q;
  logic [AW-1:0]               walk_addr;
  logic [AW-1:0]               in_addr;
  logic                        in_idx_ok;
  logic                        fast;

  assign walk_addr = AW'(walk_idx_q);
  assign in_addr   = AW'(motor_index_i);
  assign in_idx_ok = 32'(motor_index_i) < NUM_MOTORS;
  assign fast      = walk_idx_q < fgs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_idx_q <= '0;
    end else if (cmd_i.walk_start) begin
      walk_idx_q <= '0;
    end else if (cmd_i.commit) begin
      walk_idx_q <= walk_idx_q + mcsl_pkg::WALK_W'(1);
    end
  end

  // Position stores. An entry never written reads as zero.
  logic [PW-1:0]         cur_mem [NUM_MOTORS];
  logic [PW-1:0]         tgt_mem [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] cur_vld_q;
  logic [NUM_MOTORS-1:0] tgt_vld_q;
  logic [PW-1:0]         rd_cur_q;
  logic [PW-1:0]         rd_tgt_q;

  logic          cur_we;
  logic [AW-1:0] cur_waddr;
  logic [PW-1:0] cur_wdata;
  logic          tgt_we;
  logic [PW-1:0] new_pos;
  logic          moved;

  assign cur_we    = (cmd_i.store_cur && in_idx_ok) || (cmd_i.commit && moved);
  assign cur_waddr = cmd_i.commit ? walk_addr : in_addr;
  assign cur_wdata = cmd_i.commit ? new_pos : position_i;
  assign tgt_we    = cmd_i.store_tgt && in_idx_ok;

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    if (tgt_we) begin
      tgt_mem[in_addr] <= position_i;
    end
    if (cmd_i.rd_en) begin
      rd_cur_q <= cur_vld_q[walk_addr] ? cur_mem[walk_addr] : '0;
      rd_tgt_q <= tgt_vld_q[walk_addr] ? tgt_mem[walk_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= '0;
      tgt_vld_q <= '0;
    end else begin
      if (cur_we) begin
        cur_vld_q[cur_waddr] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_q[in_addr] <= 1'b1;
      end
    end
  end

  // Step toward the target, snapping onto it when within one step.
  logic [PW-1:0] step;
  logic [PW:0]   cur_plus;
  logic [PW:0]   tgt_plus;

  always_comb begin
    step     = fast ? {max_step_q, 2'b00} : {2'b00, max_step_q};
    cur_plus = {1'b0, rd_cur_q} + {1'b0, step};
    tgt_plus = {1'b0, rd_tgt_q} + {1'b0, step};
    moved    = rd_cur_q != rd_tgt_q;
    new_pos  = rd_tgt_q;
    if (rd_cur_q < rd_tgt_q) begin
      if (cur_plus < {1'b0, rd_tgt_q}) begin
        new_pos = cur_plus[PW-1:0];
      end
    end else if ({1'b0, rd_cur_q} > tgt_plus) begin
      new_pos = rd_cur_q - step;
    end
  end

  // The newest result waits here until the next moved motor or the end of
  // the walk tells whether it is the last one.
  logic                        pend_vld_q;
  logic [mcsl_pkg::IDX_W-1:0]  pend_idx_q;
  logic [PW-1:0]               pend_pos_q;
  logic                        out_vld_q;
  logic                        out_free;
  logic                        push;

  assign out_free = !out_vld_q || !out_stall_i;
  assign push     = (cmd_i.commit && moved && pend_vld_q) || cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else if (cmd_i.walk_start || cmd_i.flush) begin
      pend_vld_q <= 1'b0;
    end else if (cmd_i.commit && moved) begin
      pend_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && moved) begin
      pend_idx_q <= walk_idx_q[mcsl_pkg::IDX_W-1:0];
      pend_pos_q <= new_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      motor_index_res_o <= pend_idx_q;
      goal_position_o   <= pend_pos_q;
      last_o            <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_vld_q;

  assign sts_o.walk_end = (walk_idx_q == mcsl_pkg::WALK_W'(WALK_LEN)) || (hold_q && !fast);
  assign sts_o.moved    = moved;
  assign sts_o.pend_vld = pend_vld_q;
  assign sts_o.out_free = out_free;

endmodule
